FILE: sv/rrbw_pkg.sv
// Shared widths, command codes and word types for the round-robin bitmap worklist.
package rrbw_pkg;

  localparam int CAPACITY_DEF = 1024;

  localparam int CMD_W = 3;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;

  localparam logic [CNT_W-1:0] BLOCKS_RESET = 11'd1024;

  localparam logic [CMD_W-1:0] CMD_TAKE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ALL    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SKIP   = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] block_index;
  } rrbw_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] next_block;
    logic             found;
    logic [CNT_W-1:0] pending_count;
    logic             none_pending;
    logic             index_error;
  } rrbw_out_t;

endpackage

FILE: sv/rrbw_word_unit.sv
// Per-word bitmap logic: first-set search, in-use mask and dropped-bit count.
module rrbw_word_unit import rrbw_pkg::*; #(
  parameter int WW = 32,
  parameter int AW = 5,
  parameter int CW = 11
) (
  input  logic [WW-1:0]         word_i,
  input  logic [AW-1:0]         word_addr_i,
  input  logic [CW-1:0]         limit_i,
  input  logic                  first_i,
  input  logic [$clog2(WW)-1:0] offset_i,
  output logic                  hit_o,
  output logic [$clog2(WW)-1:0] hit_bit_o,
  output logic [WW-1:0]         keep_mask_o,
  output logic [$clog2(WW):0]   drop_cnt_o
);

  localparam int OW = $clog2(WW);

  logic [31:0]   base;
  logic [31:0]   room;
  logic [WW-1:0] scan_mask;
  logic [WW-1:0] cand;
  logic [WW-1:0] dropped;

  // bits of this word whose position lies below the limit
  always_comb begin
    base = 32'(word_addr_i) << OW;
    room = (32'(limit_i) > base) ? (32'(limit_i) - base) : 32'd0;
    for (int j = 0; j < WW; j++) begin
      keep_mask_o[j] = (32'(j) < room);
      scan_mask[j]   = !first_i || (32'(j) >= 32'(offset_i));
    end
  end

  assign cand    = word_i & scan_mask;
  assign hit_o   = |cand;
  assign dropped = word_i & ~keep_mask_o;

  // lowest set bit wins
  always_comb begin
    hit_bit_o = '0;
    for (int j = WW - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_bit_o = OW'(j);
      end
    end
  end

  always_comb begin
    drop_cnt_o = '0;
    for (int j = 0; j < WW; j++) begin
      drop_cnt_o = drop_cnt_o + (OW+1)'(dropped[j]);
    end
  end

endmodule

FILE: sv/round_robin_bitmap_worklist.sv
// Round-robin bitmap worklist: add, remove, add-all, skip and take-next over a pending bitmap.
// Add/remove: ST_RMW writes the changed word back, then ST_RESULT holds until the output is free.
// Skip, empty take, out-of-range index, unused code: straight to ST_RESULT, no bitmap access.
// Take-next: ST_SCAN reads bitmap words in turn from the scan position, wrapping, until a set bit is found.
// Add-all: ST_FILL writes the in-use mask to every word; a blocks_in_use write while idle runs a trim pass.
// Reset initialises control state, then a clearing pass zeroes all NW bitmap words (32 at default).
module round_robin_bitmap_worklist import rrbw_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rrbw_in_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rrbw_out_t        out_word_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i
);

  // Geometry: bitmap held as NW words of WW bits in one synchronous RAM.
  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CAPACITY < 32) ? (2 ** PW) : 32;
  localparam int OW = $clog2(WW);
  localparam int NW = (CAPACITY + WW - 1) / WW;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;

  localparam logic [AW-1:0] LAST_ADDR = AW'(NW - 1);

  // Sequencer state codes
  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_RMW     = 3'd2;
  localparam logic [2:0] ST_SCAN    = 3'd3;
  localparam logic [2:0] ST_FILL    = 3'd4;
  localparam logic [2:0] ST_TRIM_RD = 3'd5;
  localparam logic [2:0] ST_TRIM_WR = 3'd6;
  localparam logic [2:0] ST_RESULT  = 3'd7;

  function automatic logic [CW-1:0] clamp_count(input logic [CNT_W-1:0] v);
    logic [31:0] n;
    n = 32'(v);
    if (n == 32'd0) n = 32'd1;
    if (n > 32'(CAPACITY)) n = 32'(CAPACITY);
    return CW'(n);
  endfunction

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos,
                                            input logic [CW-1:0] lim);
    logic [31:0] p;
    p = 32'(pos) + 32'd1;
    if (p >= 32'(lim)) p = 32'd0;
    return PW'(p);
  endfunction

  // Control state
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] nb_q, nb_d;          // blocks in use, clamped
  logic [CW-1:0] total_q, total_d;    // pending count
  logic [PW-1:0] pos_q, pos_d;        // scan position
  logic [AW-1:0] sa_q, sa_d;          // sweep address
  logic          out_valid_q, out_valid_d;

  // Per-command working registers
  logic [AW-1:0] waddr_q, waddr_d;
  logic [OW-1:0] bit_q, bit_d;
  logic          is_add_q, is_add_d;
  logic          first_q, first_d;
  logic [PW-1:0] taken_q, taken_d;
  logic          found_q, found_d;
  logic          err_q, err_d;
  rrbw_out_t     out_q, out_d;

  // Bitmap RAM
  logic [WW-1:0] bitmap_q [NW];
  logic [WW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [WW-1:0] mem_wd;

  // Word unit hookup
  logic [AW-1:0]  unit_addr;
  logic           hit;
  logic [OW-1:0]  hit_bit;
  logic [WW-1:0]  keep_mask;
  logic [OW:0]    drop_cnt;

  logic           accept;
  logic           out_free;
  logic           idx_bad;
  logic [AW-1:0]  idx_addr;
  logic [AW-1:0]  last_word;
  logic [AW-1:0]  scan_next;
  logic [CW-1:0]  nb_new;

  assign unit_addr = (state_q == ST_SCAN) ? waddr_q : sa_q;

  rrbw_word_unit #(
    .WW (WW),
    .AW (AW),
    .CW (CW)
  ) u_word (
    .word_i      (rdata_q),
    .word_addr_i (unit_addr),
    .limit_i     (nb_q),
    .first_i     (first_q),
    .offset_i    (OW'(pos_q)),
    .hit_o       (hit),
    .hit_bit_o   (hit_bit),
    .keep_mask_o (keep_mask),
    .drop_cnt_o  (drop_cnt)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_we_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign idx_bad   = (32'(in_word_i.block_index) >= 32'(nb_q));
  assign idx_addr  = AW'(32'(in_word_i.block_index) >> OW);
  // last word holding an in-use index; scan wraps after it
  assign last_word = AW'((32'(nb_q) - 32'd1) >> OW);
  assign scan_next = (waddr_q == last_word) ? '0 : AW'(waddr_q + AW'(1));
  assign nb_new    = clamp_count(cfg_data_i);

  always_comb begin
    state_d     = state_q;
    nb_d        = nb_q;
    total_d     = total_q;
    pos_d       = pos_q;
    sa_d        = sa_q;
    out_valid_d = out_valid_q;
    waddr_d     = waddr_q;
    bit_d       = bit_q;
    is_add_d    = is_add_q;
    first_d     = first_q;
    taken_d     = taken_q;
    found_d     = found_q;
    err_d       = err_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wa      = sa_q;
    mem_ra      = sa_q;
    mem_wd      = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (sa_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          sa_d = AW'(sa_q + AW'(1));
        end
      end

      ST_IDLE: begin
        if (accept) begin
          taken_d = '0;
          found_d = 1'b0;
          err_d   = 1'b0;
          state_d = ST_RESULT;
          case (in_word_i.command)
            CMD_TAKE: begin
              if (total_q != '0) begin
                mem_re  = 1'b1;
                mem_ra  = AW'(32'(pos_q) >> OW);
                waddr_d = AW'(32'(pos_q) >> OW);
                first_d = 1'b1;
                state_d = ST_SCAN;
              end
            end
            CMD_ADD, CMD_REMOVE: begin
              if (idx_bad) begin
                err_d = 1'b1;
              end else begin
                mem_re   = 1'b1;
                mem_ra   = idx_addr;
                waddr_d  = idx_addr;
                bit_d    = OW'(in_word_i.block_index);
                is_add_d = (in_word_i.command == CMD_ADD);
                state_d  = ST_RMW;
              end
            end
            CMD_ALL: begin
              sa_d    = '0;
              total_d = nb_q;
              pos_d   = '0;
              state_d = ST_FILL;
            end
            CMD_SKIP: begin
              if (total_q != '0) begin
                pos_d = advance(pos_q, nb_q);
              end
            end
            default: ;
          endcase
        end
      end

      ST_RMW: begin
        mem_wa = waddr_q;
        if (is_add_q && !rdata_q[bit_q]) begin
          mem_we  = 1'b1;
          mem_wd  = rdata_q | (WW'(1) << bit_q);
          total_d = CW'(total_q + CW'(1));
        end else if (!is_add_q && rdata_q[bit_q]) begin
          mem_we  = 1'b1;
          mem_wd  = rdata_q & ~(WW'(1) << bit_q);
          total_d = CW'(total_q - CW'(1));
        end
        state_d = ST_RESULT;
      end

      ST_SCAN: begin
        // one word per cycle; the start word comes round again unmasked on wrap
        if (hit) begin
          mem_we  = 1'b1;
          mem_wa  = waddr_q;
          mem_wd  = rdata_q & ~(WW'(1) << hit_bit);
          total_d = CW'(total_q - CW'(1));
          taken_d = PW'({waddr_q, hit_bit});
          found_d = 1'b1;
          pos_d   = advance(PW'({waddr_q, hit_bit}), nb_q);
          state_d = ST_RESULT;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = scan_next;
          waddr_d = scan_next;
          first_d = 1'b0;
        end
      end

      ST_FILL: begin
        mem_we = 1'b1;
        mem_wd = keep_mask;
        if (sa_q == LAST_ADDR) begin
          state_d = ST_RESULT;
        end else begin
          sa_d = AW'(sa_q + AW'(1));
        end
      end

      ST_TRIM_RD: begin
        mem_re  = 1'b1;
        state_d = ST_TRIM_WR;
      end

      ST_TRIM_WR: begin
        mem_we  = 1'b1;
        mem_wd  = rdata_q & keep_mask;
        total_d = CW'(total_q - CW'(drop_cnt));
        if (sa_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          sa_d    = AW'(sa_q + AW'(1));
          state_d = ST_TRIM_RD;
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.next_block        = IDX_W'(taken_q);
          out_d.found             = found_q;
          out_d.pending_count     = CNT_W'(total_q);
          out_d.none_pending      = (total_q == '0);
          out_d.index_error       = err_q;
          state_d                 = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Count register write: takes effect at once; when idle, a trim pass
    // drops pending bits that now lie beyond the count.
    if (cfg_we_i) begin
      nb_d = nb_new;
      if (32'(pos_q) >= 32'(nb_new)) begin
        pos_d = '0;
      end
      if (state_q == ST_IDLE) begin
        sa_d    = '0;
        state_d = ST_TRIM_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      nb_q        <= clamp_count(BLOCKS_RESET);
      total_q     <= '0;
      pos_q       <= '0;
      sa_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nb_q        <= nb_d;
      total_q     <= total_d;
      pos_q       <= pos_d;
      sa_q        <= sa_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_q  <= waddr_d;
    bit_q    <= bit_d;
    is_add_q <= is_add_d;
    first_q  <= first_d;
    taken_q  <= taken_d;
    found_q  <= found_d;
    err_q    <= err_d;
    out_q    <= out_d;
  end

  // Bitmap RAM, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= bitmap_q[mem_ra];
    end
  end

endmodule
